### rtl/core/pc_score_table_with_replacement_defines.svh
// Assertion macros used by the score table RTL.
// Files that check their own logic include this header; it depends on nothing.
`ifndef PC_SCORE_TABLE_WITH_REPLACEMENT_DEFINES_SVH
`define PC_SCORE_TABLE_WITH_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PCST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pc score table check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PCST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pc score table check failed");

`endif

### rtl/core/pcst_pkg.sv
// Shared types and constants of the score table.
// No dependencies; pcst_cell and the top module of the block use it.
package pcst_pkg;

  typedef enum logic [1:0] {
    REQ_ADD     = 2'd0,
    REQ_TRIED   = 2'd1,
    REQ_MATCHED = 2'd2,
    REQ_QUERY   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SEARCH_MUL,
    ST_SEARCH_CMP,
    ST_REPLACE,
    ST_EMIT_MUL,
    ST_EMIT_CMP,
    ST_EMPTY
  } state_e;

  localparam int unsigned CFG_INDEX_BITS = 8;
  localparam int unsigned CFG_DATA_BITS  = 8;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_REPLACE_POLICY = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ENTRIES_IN_USE = 8'd1;

  localparam logic POLICY_LOWEST_SCORE = 1'b0;

  // Write commands for one cell.
  typedef struct packed {
    logic new_entry;
    logic set_time;
    logic inc_tried;
    logic inc_matched;
  } cell_wr_t;

endpackage

### rtl/core/pcst_cell.sv
// One table slot: address, timestamp and the two saturating counters.
// Depends on pcst_pkg; takes part in the first-match priority chain.
module pcst_cell #(
  parameter int unsigned PC_BITS    = 48,
  parameter int unsigned TIME_BITS  = 48,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  pcst_pkg::cell_wr_t    wr_i,
  input  logic [PC_BITS-1:0]    wr_pc_i,
  input  logic [TIME_BITS-1:0]  wr_time_i,
  input  logic [PC_BITS-1:0]    lookup_pc_i,
  input  logic                  in_use_i,
  input  logic                  prior_hit_i,
  output logic                  prior_hit_o,
  output logic                  match_o,
  output logic [PC_BITS-1:0]    pc_o,
  output logic [TIME_BITS-1:0]  time_o,
  output logic [COUNT_BITS-1:0] tried_o,
  output logic [COUNT_BITS-1:0] matched_o
);

  logic [PC_BITS-1:0]    pc_q;
  logic [TIME_BITS-1:0]  time_q;
  logic [COUNT_BITS-1:0] tried_q;
  logic [COUNT_BITS-1:0] matched_q;
  logic                  same;

  assign same        = in_use_i && (pc_q == lookup_pc_i);
  assign match_o     = same && !prior_hit_i;
  assign prior_hit_o = prior_hit_i || same;

  always_ff @(posedge clk_i) begin
    if (wr_i.new_entry) begin
      pc_q      <= wr_pc_i;
      time_q    <= wr_time_i;
      tried_q   <= '0;
      matched_q <= '0;
    end else begin
      if (wr_i.set_time) begin
        time_q <= wr_time_i;
      end
      if (wr_i.inc_tried && (tried_q != '1)) begin
        tried_q <= tried_q + COUNT_BITS'(1);
      end
      if (wr_i.inc_matched && (matched_q != '1)) begin
        matched_q <= matched_q + COUNT_BITS'(1);
      end
    end
  end

  assign pc_o      = pc_q;
  assign time_o    = time_q;
  assign tried_o   = tried_q;
  assign matched_o = matched_q;

endmodule

### rtl/core/pcst_score_cmp.sv
// Exact score comparator: forms (matched+1)/tried, or 3/1, and cross-multiplies.
// Products are registered, so lt/gt reflect the inputs of the cycle before.
module pcst_score_cmp #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic [COUNT_BITS-1:0] a_tried_i,
  input  logic [COUNT_BITS-1:0] a_matched_i,
  input  logic [COUNT_BITS:0]   b_num_i,
  input  logic [COUNT_BITS-1:0] b_den_i,
  output logic [COUNT_BITS:0]   a_num_o,
  output logic [COUNT_BITS-1:0] a_den_o,
  output logic                  lt_o,
  output logic                  gt_o
);

  localparam int unsigned PW = 2 * COUNT_BITS + 1;

  logic [PW-1:0] l_q;
  logic [PW-1:0] r_q;

  always_comb begin
    if (a_tried_i == '0) begin
      a_num_o = (COUNT_BITS + 1)'(3);
      a_den_o = COUNT_BITS'(1);
    end else begin
      a_num_o = {1'b0, a_matched_i} + (COUNT_BITS + 1)'(1);
      a_den_o = a_tried_i;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q <= PW'(a_num_o) * PW'(b_den_i);
    r_q <= PW'(b_num_i) * PW'(a_den_o);
  end

  assign lt_o = l_q < r_q;
  assign gt_o = l_q > r_q;

endmodule

### rtl/core/pc_score_table_with_replacement.sv
// Fully associative score table of instruction addresses, kept as a row of
// cells, one per slot. Each cell compares its address with the request, and a
// priority chain through the row picks the first matching slot. An add that
// hits, an append into a free slot and a profile update each pass through
// the decide state alone before ready rises again. Replacement in a full
// table and the query walk the filled slots through one shared comparator
// that registers its cross-multiplied products, so each visited slot passes
// a multiply and then a compare state; a query searches, then walks again to
// emit and may stall on the result side. Query results leave through an output
// register, one transfer per address that holds the highest score, in slot
// order, tlast on the final one; an empty table gives one result with
// found clear. There is no clearing pass after reset; only slots below the
// fill count are ever read. Depends on pcst_pkg, pcst_cell and pcst_score_cmp.
`include "pc_score_table_with_replacement_defines.svh"

module pc_score_table_with_replacement #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned PC_BITS    = 48,
  parameter int unsigned TIME_BITS  = 48,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pcst_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [pcst_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  // Request stream.
  input  logic                               s_tvalid_i,
  output logic                               s_tready_o,
  // s_tdata_i fields, low bit up: pc, timestamp, zero fill.
  input  logic [((PC_BITS+TIME_BITS+7)/8)*8-1:0] s_tdata_i,
  // s_tuser_i fields, low bit up: req_type.
  input  logic [1:0]                         s_tuser_i,
  // Result stream.
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  // m_tdata_o fields, low bit up: best_pc, zero fill.
  output logic [((PC_BITS+7)/8)*8-1:0]       m_tdata_o,
  // m_tuser_o fields, low bit up: found.
  output logic                               m_tuser_o,
  output logic                               m_tlast_o
);

  localparam int unsigned FW  = $clog2(ENTRIES + 1);
  localparam int unsigned IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OUT_W = ((PC_BITS + 7) / 8) * 8;

  // Configuration registers; the port never stalls.
  logic       policy_q;
  logic [4:0] eiu_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= pcst_pkg::POLICY_LOWEST_SCORE;
      eiu_q    <= 5'd16;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == pcst_pkg::CFG_REPLACE_POLICY) begin
        policy_q <= cfg_data_i[0];
      end else if (cfg_index_i == pcst_pkg::CFG_ENTRIES_IN_USE) begin
        eiu_q <= cfg_data_i[4:0];
      end
    end
  end

  // Effective capacity: zero acts as one, anything above ENTRIES as ENTRIES.
  logic [FW-1:0] cap;
  always_comb begin
    if (eiu_q == 5'd0) begin
      cap = FW'(1);
    end else if (32'(eiu_q) > ENTRIES) begin
      cap = FW'(ENTRIES);
    end else begin
      cap = FW'(eiu_q);
    end
  end

  // Control and request registers.
  pcst_pkg::state_e state_q, state_d;
  logic [FW-1:0]        fill_q, fill_d;
  pcst_pkg::req_e       req_q;
  logic [PC_BITS-1:0]   req_pc_q;
  logic [TIME_BITS-1:0] req_time_q;
  logic [IW-1:0]        idx_q, idx_d;
  logic [IW-1:0]        cand_q, cand_d;
  logic [IW-1:0]        last_eq_q, last_eq_d;
  logic [COUNT_BITS:0]  cand_num_q, cand_num_d;
  logic [COUNT_BITS-1:0] cand_den_q, cand_den_d;
  logic [TIME_BITS-1:0] cand_time_q, cand_time_d;

  logic                 out_valid_q, out_valid_d;
  logic [PC_BITS-1:0]   out_pc_q, out_pc_d;
  logic                 out_found_q, out_found_d;
  logic                 out_last_q, out_last_d;

  logic in_xfer;
  assign s_tready_o = (state_q == pcst_pkg::ST_IDLE);
  assign in_xfer    = s_tvalid_i && s_tready_o;

  // The cell row.
  pcst_pkg::cell_wr_t    cell_wr   [ENTRIES];
  logic [PC_BITS-1:0]    cell_pc   [ENTRIES];
  logic [TIME_BITS-1:0]  cell_time [ENTRIES];
  logic [COUNT_BITS-1:0] cell_tried[ENTRIES];
  logic [COUNT_BITS-1:0] cell_match_cnt[ENTRIES];
  logic [ENTRIES-1:0]    cell_hit;
  logic [ENTRIES:0]      chain;

  assign chain[0] = 1'b0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    pcst_cell #(
      .PC_BITS   (PC_BITS),
      .TIME_BITS (TIME_BITS),
      .COUNT_BITS(COUNT_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .wr_i       (cell_wr[g]),
      .wr_pc_i    (req_pc_q),
      .wr_time_i  (req_time_q),
      .lookup_pc_i(req_pc_q),
      .in_use_i   (FW'(g) < fill_q),
      .prior_hit_i(chain[g]),
      .prior_hit_o(chain[g+1]),
      .match_o    (cell_hit[g]),
      .pc_o       (cell_pc[g]),
      .time_o     (cell_time[g]),
      .tried_o    (cell_tried[g]),
      .matched_o  (cell_match_cnt[g])
    );
  end

  logic hit_any;
  assign hit_any = chain[ENTRIES];

  // Shared comparator: the slot under the walk pointer against the candidate.
  logic [COUNT_BITS:0]   a_num;
  logic [COUNT_BITS-1:0] a_den;
  logic                  cmp_lt, cmp_gt;

  pcst_score_cmp #(
    .COUNT_BITS(COUNT_BITS)
  ) u_cmp (
    .clk_i      (clk_i),
    .a_tried_i  (cell_tried[idx_q]),
    .a_matched_i(cell_match_cnt[idx_q]),
    .b_num_i    (cand_num_q),
    .b_den_i    (cand_den_q),
    .a_num_o    (a_num),
    .a_den_o    (a_den),
    .lt_o       (cmp_lt),
    .gt_o       (cmp_gt)
  );

  logic table_full, walk_end, out_free, take_new, is_best;
  assign table_full = fill_q >= cap;
  assign walk_end   = (FW'(idx_q) + FW'(1)) == fill_q;
  assign out_free   = !out_valid_q || m_tready_i;
  assign is_best    = !cmp_lt && !cmp_gt;
  assign take_new   = (policy_q == pcst_pkg::POLICY_LOWEST_SCORE) ? cmp_lt
                                                                  : (cell_time[idx_q] < cand_time_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcst_pkg::ST_IDLE: begin
        if (in_xfer) state_d = pcst_pkg::ST_DECIDE;
      end
      pcst_pkg::ST_DECIDE: begin
        state_d = pcst_pkg::ST_IDLE;
        if (req_q == pcst_pkg::REQ_ADD) begin
          if (!hit_any && table_full) begin
            state_d = (fill_q == FW'(1)) ? pcst_pkg::ST_REPLACE : pcst_pkg::ST_SEARCH_MUL;
          end
        end else if (req_q == pcst_pkg::REQ_QUERY) begin
          if (fill_q == '0) begin
            state_d = pcst_pkg::ST_EMPTY;
          end else if (fill_q == FW'(1)) begin
            state_d = pcst_pkg::ST_EMIT_MUL;
          end else begin
            state_d = pcst_pkg::ST_SEARCH_MUL;
          end
        end
      end
      pcst_pkg::ST_SEARCH_MUL: state_d = pcst_pkg::ST_SEARCH_CMP;
      pcst_pkg::ST_SEARCH_CMP: begin
        if (walk_end) begin
          state_d = (req_q == pcst_pkg::REQ_ADD) ? pcst_pkg::ST_REPLACE
                                                 : pcst_pkg::ST_EMIT_MUL;
        end else begin
          state_d = pcst_pkg::ST_SEARCH_MUL;
        end
      end
      pcst_pkg::ST_REPLACE: state_d = pcst_pkg::ST_IDLE;
      pcst_pkg::ST_EMIT_MUL: state_d = pcst_pkg::ST_EMIT_CMP;
      pcst_pkg::ST_EMIT_CMP: begin
        if (!is_best) begin
          state_d = pcst_pkg::ST_EMIT_MUL;
        end else if (out_free) begin
          state_d = (idx_q == last_eq_q) ? pcst_pkg::ST_IDLE : pcst_pkg::ST_EMIT_MUL;
        end
      end
      pcst_pkg::ST_EMPTY: begin
        if (out_free) state_d = pcst_pkg::ST_IDLE;
      end
      default: state_d = pcst_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: cell writes, walk registers, result register.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      cell_wr[i] = '0;
    end
    fill_d      = fill_q;
    idx_d       = idx_q;
    cand_d      = cand_q;
    last_eq_d   = last_eq_q;
    cand_num_d  = cand_num_q;
    cand_den_d  = cand_den_q;
    cand_time_d = cand_time_q;
    out_valid_d = out_valid_q && !m_tready_i;
    out_pc_d    = out_pc_q;
    out_found_d = out_found_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      pcst_pkg::ST_IDLE: begin
        idx_d = '0;
      end
      pcst_pkg::ST_DECIDE: begin
        // The pointer sits on slot zero: it seeds the candidate.
        cand_d      = '0;
        last_eq_d   = '0;
        cand_num_d  = a_num;
        cand_den_d  = a_den;
        cand_time_d = cell_time[idx_q];
        idx_d       = (fill_q > FW'(1)) ? IW'(1) : '0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (req_q == pcst_pkg::REQ_ADD) begin
            cell_wr[i].set_time  = cell_hit[i];
            cell_wr[i].new_entry = !hit_any && !table_full && (FW'(i) == fill_q);
          end else if (req_q == pcst_pkg::REQ_TRIED) begin
            cell_wr[i].inc_tried = cell_hit[i];
          end else if (req_q == pcst_pkg::REQ_MATCHED) begin
            cell_wr[i].inc_matched = cell_hit[i];
          end
        end
        if ((req_q == pcst_pkg::REQ_ADD) && !hit_any && !table_full) begin
          fill_d = fill_q + FW'(1);
        end
      end
      pcst_pkg::ST_SEARCH_MUL: begin
      end
      pcst_pkg::ST_SEARCH_CMP: begin
        if (req_q == pcst_pkg::REQ_ADD) begin
          if (take_new) begin
            cand_d      = idx_q;
            cand_num_d  = a_num;
            cand_den_d  = a_den;
            cand_time_d = cell_time[idx_q];
          end
        end else if (cmp_gt) begin
          cand_d     = idx_q;
          last_eq_d  = idx_q;
          cand_num_d = a_num;
          cand_den_d = a_den;
        end else if (is_best) begin
          last_eq_d = idx_q;
        end
        idx_d = walk_end ? '0 : idx_q + IW'(1);
      end
      pcst_pkg::ST_REPLACE: begin
        for (int i = 0; i < ENTRIES; i++) begin
          cell_wr[i].new_entry = (IW'(i) == cand_q);
        end
      end
      pcst_pkg::ST_EMIT_MUL: begin
      end
      pcst_pkg::ST_EMIT_CMP: begin
        if (!is_best) begin
          idx_d = idx_q + IW'(1);
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_pc_d    = cell_pc[idx_q];
          out_found_d = 1'b1;
          out_last_d  = (idx_q == last_eq_q);
          if (idx_q != last_eq_q) idx_d = idx_q + IW'(1);
        end
      end
      pcst_pkg::ST_EMPTY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pc_d    = '0;
          out_found_d = 1'b0;
          out_last_d  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcst_pkg::ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q      <= pcst_pkg::req_e'(s_tuser_i);
      req_pc_q   <= s_tdata_i[PC_BITS-1:0];
      req_time_q <= s_tdata_i[PC_BITS+TIME_BITS-1:PC_BITS];
    end
    idx_q       <= idx_d;
    cand_q      <= cand_d;
    last_eq_q   <= last_eq_d;
    cand_num_q  <= cand_num_d;
    cand_den_q  <= cand_den_d;
    cand_time_q <= cand_time_d;
    out_pc_q    <= out_pc_d;
    out_found_q <= out_found_d;
    out_last_q  <= out_last_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = OUT_W'(out_pc_q);
  assign m_tuser_o  = out_found_q;
  assign m_tlast_o  = out_last_q;

  // The fill count never passes the table size and grows by one at most.
  `PCST_ASSERT_NOW(a_fill_bound, 1'b1, 32'(fill_q) <= ENTRIES)
  `PCST_ASSERT_NEXT(a_fill_step, 1'b1,
                    (fill_q == $past(fill_q)) || (fill_q == $past(fill_q) + FW'(1)))
  // A result without a valid address is always the final one.
  `PCST_ASSERT_NOW(a_empty_last, m_tvalid_o && !m_tuser_o, m_tlast_o)
  // The walk pointer stays inside the filled slots.
  `PCST_ASSERT_NOW(a_walk_bound,
                   (state_q == pcst_pkg::ST_SEARCH_CMP) || (state_q == pcst_pkg::ST_EMIT_CMP),
                   FW'(idx_q) < fill_q)

endmodule
